// ----- design/kms_pkg.sv -----
// Shared types and constants for the keyboard matrix scanner.
`default_nettype none

package kms_pkg;

	// Field widths of the command and result items
	localparam int OPCODE_W = 3;
	localparam int KEY_W    = 7;
	localparam int DATA_W   = 8;
	localparam int LED_W    = 6;

	// Bit positions inside a port write byte
	localparam int BIT_START = 6;
	localparam int BIT_BELL  = 7;

	// Command opcodes; the two spare codes do nothing
	typedef enum logic [OPCODE_W-1:0] {
		OP_PRESS      = 3'd0,
		OP_RELEASE    = 3'd1,
		OP_WRITE      = 3'd2,
		OP_READ       = 3'd3,
		OP_SCAN_TICK  = 3'd4,
		OP_READY_TICK = 3'd5
	} op_t;

	// Controller sequencing
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

`default_nettype wire

// ----- design/kms_if.sv -----
// Handshake channels for command and result items.
`default_nettype none

interface kms_cmd_if import kms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [KEY_W-1:0]    key_code;
	logic [DATA_W-1:0]   write_data;

	modport source (output valid, output opcode, output key_code, output write_data,
		input ready);
	modport sink (input valid, input opcode, input key_code, input write_data,
		output ready);
endinterface

interface kms_res_if import kms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              interrupt;
	logic              ready_res;
	logic              bell;
	logic [LED_W-1:0]  led_bits;
	logic              scanning_active;

	modport source (output valid, output read_data, output interrupt, output ready_res,
		output bell, output led_bits, output scanning_active, input ready);
	modport sink (input valid, input read_data, input interrupt, input ready_res,
		input bell, input led_bits, input scanning_active, output ready);
endinterface

`default_nettype wire

// ----- design/keyboard_matrix_scanner.sv -----
// Keyboard matrix scanner top level: controller, scan walk and result register.
//
//   channel  dir  handshake        payload
//   cmd      in   valid / ready    opcode, key_code, write_data
//   res      out  valid / ready    read_data, interrupt, ready_res, bell,
//                                  led_bits, scanning_active
//
// Items other than scan steps have their result registered at the accept edge.
// After a scan step is accepted, the walk reads the key map
// through its single read port, one entry per cycle, until a down key or the end.
// After reset a clearing pass writes every key map entry, the last one as down; no item is taken.
// One item is in work at a time; a new item is taken once the result register is free
// or being emptied in the same cycle.
`default_nettype none

module keyboard_matrix_scanner import kms_pkg::*; #(
	parameter int NUM_KEYS = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kms_cmd_if.sink   cmd,
	kms_res_if.source res
);

	localparam int ADDR_W = $clog2(NUM_KEYS);
	localparam int POS_W  = $clog2(NUM_KEYS + 1);
	localparam logic [POS_W-1:0]  POS_END  = POS_W'(NUM_KEYS);
	localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(NUM_KEYS - 1);

	state_t state_q, state_d;
	op_t    op;

	logic [ADDR_W-1:0] clr_ptr_q;
	logic              cmd_acc;
	logic              key_ok;

	// Architectural state
	logic [POS_W-1:0]  scan_pos_q, n_scan_pos;
	logic [DATA_W-1:0] latched_q, n_latched;
	logic              ready_q, n_ready;
	logic              irq_q, n_irq;
	logic [LED_W-1:0]  led_q, n_led;
	logic              sarm_q, n_sarm;
	logic              rarm_q, n_rarm;
	logic              bell_q, n_bell;

	// Scan walk pipeline
	logic              chk_vld_s1, n_chk_vld;
	logic [ADDR_W-1:0] chk_pos_s1, n_chk_pos;
	logic              hit;
	logic              go_scan;
	logic              res_load;
	logic [DATA_W-1:0] res_rd;
	logic              scan_idle;

	// Result register
	logic              res_vld_q;
	logic [DATA_W-1:0] res_rd_q;
	logic              res_irq_q;
	logic              res_rdy_q;
	logic              res_bell_q;
	logic [LED_W-1:0]  res_led_q;
	logic              res_scan_q;

	// Key map port
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_wdata;
	logic              mem_rdata;

	kms_keymap_ram #(.DEPTH(NUM_KEYS)) u_keymap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (scan_pos_q[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	assign op        = op_t'(cmd.opcode);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign key_ok    = 32'(cmd.key_code) < 32'(NUM_KEYS);
	assign hit       = chk_vld_s1 && mem_rdata;
	assign scan_idle = scan_pos_q == POS_END;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_ptr_q == ADDR_TOP) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_acc && go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and key map writes
	always_comb begin
		cmd.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(cmd.key_code);
		mem_wdata = op == OP_PRESS;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_ptr_q;
				mem_wdata = clr_ptr_q == ADDR_TOP;
			end
			ST_IDLE: begin
				cmd.ready = !res_vld_q || res.ready;
				mem_we    = cmd.valid && cmd.ready && key_ok
					&& (op == OP_PRESS || op == OP_RELEASE);
			end
			default: ;
		endcase
	end

	// Item decode and scan walk
	always_comb begin
		n_scan_pos = scan_pos_q;
		n_latched  = latched_q;
		n_ready    = ready_q;
		n_irq      = irq_q;
		n_led      = led_q;
		n_sarm     = sarm_q;
		n_rarm     = rarm_q;
		n_bell     = bell_q;
		n_chk_vld  = 1'b0;
		n_chk_pos  = chk_pos_s1;
		go_scan    = 1'b0;
		res_load   = 1'b0;
		res_rd     = '0;
		if (cmd_acc) begin
			n_bell = 1'b0;
			case (op)
				OP_PRESS, OP_RELEASE: ;
				OP_WRITE: begin
					if (ready_q) begin
						n_led   = cmd.write_data[LED_W-1:0];
						n_bell  = cmd.write_data[BIT_BELL];
						n_ready = 1'b0;
						n_rarm  = 1'b1;
						if (cmd.write_data[BIT_START] && scan_idle) begin
							go_scan    = 1'b1;
							n_scan_pos = '0;
						end
					end
				end
				OP_READ: begin
					n_irq  = 1'b0;
					res_rd = latched_q;
				end
				OP_SCAN_TICK: begin
					if (sarm_q) begin
						n_sarm  = 1'b0;
						go_scan = !scan_idle;
					end
				end
				OP_READY_TICK: begin
					if (rarm_q) begin
						n_rarm  = 1'b0;
						n_ready = 1'b1;
					end
				end
				default: ;
			endcase
			res_load = !go_scan;
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				// Down key found: latch it and stop after it
				n_latched  = 8'(chk_pos_s1);
				n_irq      = 1'b1;
				n_sarm     = 1'b1;
				n_scan_pos = POS_W'(chk_pos_s1) + POS_W'(1);
				res_load   = 1'b1;
			end else if (scan_idle) begin
				res_load = 1'b1;
			end else begin
				n_chk_vld  = 1'b1;
				n_chk_pos  = scan_pos_q[ADDR_W-1:0];
				n_scan_pos = scan_pos_q + POS_W'(1);
			end
		end
	end

	// Control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_ptr_q  <= '0;
			scan_pos_q <= POS_END;
			latched_q  <= '0;
			ready_q    <= 1'b1;
			irq_q      <= 1'b0;
			led_q      <= '0;
			sarm_q     <= 1'b0;
			rarm_q     <= 1'b0;
			chk_vld_s1 <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
			end
			scan_pos_q <= n_scan_pos;
			latched_q  <= n_latched;
			ready_q    <= n_ready;
			irq_q      <= n_irq;
			led_q      <= n_led;
			sarm_q     <= n_sarm;
			rarm_q     <= n_rarm;
			chk_vld_s1 <= n_chk_vld;
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		bell_q     <= n_bell;
		chk_pos_s1 <= n_chk_pos;
		if (res_load) begin
			res_rd_q   <= res_rd;
			res_irq_q  <= n_irq;
			res_rdy_q  <= n_ready;
			res_bell_q <= n_bell;
			res_led_q  <= n_led;
			res_scan_q <= n_scan_pos != POS_END;
		end
	end

	assign res.valid           = res_vld_q;
	assign res.read_data       = res_rd_q;
	assign res.interrupt       = res_irq_q;
	assign res.ready_res       = res_rdy_q;
	assign res.bell            = res_bell_q;
	assign res.led_bits        = res_led_q;
	assign res.scanning_active = res_scan_q;

	// The result slot stays empty while a walk is running
	a_scan_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !res_vld_q)
		else $error("result pending during scan walk");

	// A map read in flight belongs to a walk
	a_check_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> state_q == ST_SCAN)
		else $error("key map check outside scan walk");

	// The scan position never passes the end
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_pos_q <= POS_END)
		else $error("scan position beyond end");

	// An accepted write makes the controller busy
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && op == OP_WRITE && ready_q |=> !ready_q && rarm_q)
		else $error("write did not go busy");

endmodule

`default_nettype wire

// ----- design/kms_keymap_ram.sv -----
// Key-down map: one-bit synchronous RAM, one write and one registered read port.
`default_nettype none

module kms_keymap_ram #(
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic mem_q [DEPTH];
	logic rdata_q;

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- bench/tb_keyboard_matrix_scanner.sv -----
// Self-checking bench for the keyboard matrix scanner: directed table, then random items.
`default_nettype none

module tb_keyboard_matrix_scanner;
	import kms_pkg::*;

	localparam int NUM_KEYS       = 128;
	localparam int TAIL_CYCLES    = NUM_KEYS + 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_ITEMS   = 1625;
	localparam int MAX_REPORTS    = 10;

	// One status item as the block reports it
	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              interrupt;
		logic              ready_res;
		logic              bell;
		logic [LED_W-1:0]  led_bits;
		logic              scanning_active;
	} status_t;

	// One row of the directed table; typed rows carry their own expected status
	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
		logic              typed;
		status_t           want;
	} stim_row_t;

	localparam status_t AT_RESET  = '{8'h00, 1'b0, 1'b1, 1'b0, 6'h00, 1'b0};
	localparam status_t NOT_TYPED = '0;

	localparam int DIRECTED_ROWS = 25;
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_READ,       7'd0,   8'h00, 1'b1, AT_RESET},
		'{OP_SCAN_TICK,  7'd0,   8'h00, 1'b1, AT_RESET},
		'{OP_READY_TICK, 7'd0,   8'h00, 1'b1, AT_RESET},
		'{OP_PRESS,      7'd0,   8'h00, 1'b1, AT_RESET},
		'{OP_PRESS,      7'd127, 8'h00, 1'b0, NOT_TYPED},
		'{OP_PRESS,      7'd64,  8'h00, 1'b0, NOT_TYPED},
		'{OP_WRITE,      7'd0,   8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, 6'h3F, 1'b1}},
		'{OP_WRITE,      7'd0,   8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 6'h3F, 1'b1}},
		'{OP_READ,       7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_SCAN_TICK,  7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_READY_TICK, 7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_WRITE,      7'd0,   8'h40, 1'b0, NOT_TYPED},
		'{OP_READ,       7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_SCAN_TICK,  7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_SCAN_TICK,  7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_SCAN_TICK,  7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_READY_TICK, 7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_RELEASE,    7'd127, 8'h00, 1'b0, NOT_TYPED},
		'{OP_RELEASE,    7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_RELEASE,    7'd64,  8'h00, 1'b0, NOT_TYPED},
		'{OP_WRITE,      7'd0,   8'hC0, 1'b0, NOT_TYPED},
		'{OP_READY_TICK, 7'd0,   8'h00, 1'b0, NOT_TYPED},
		'{OP_PRESS,      7'd127, 8'h00, 1'b0, NOT_TYPED},
		'{OP_PRESS,      7'd85,  8'h00, 1'b0, NOT_TYPED},
		'{OP_WRITE,      7'd0,   8'h7F, 1'b0, NOT_TYPED}
	};

	logic clk;
	logic arst_n;

	kms_cmd_if cmd_ch ();
	kms_res_if res_ch ();

	keyboard_matrix_scanner #(
		.NUM_KEYS(NUM_KEYS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// Predictor state
	logic [NUM_KEYS-1:0] keys_down;
	logic [8:0]          scan_pos;
	logic [DATA_W-1:0]   code_latch;
	logic [DATA_W-1:0]   last_byte;
	bit                  write_ready;
	bit                  irq_level;
	bit                  scan_tick_due;
	bit                  ready_tick_due;

	status_t status_due [$];

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned hold_asked;
	int unsigned fault_count;
	int unsigned stuck_cycles;

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Walk the key map from the scan position to the next down key
	function automatic void walk_key_map();
		logic [8:0] pos;
		while (scan_pos < NUM_KEYS) begin
			pos = scan_pos;
			scan_pos = scan_pos + 9'd1;
			if (keys_down[pos]) begin
				code_latch = pos[7:0];
				irq_level = 1'b1;
				scan_tick_due = 1'b1;
				return;
			end
		end
		scan_pos = 9'(NUM_KEYS);
	endfunction

	// Apply one command to the predicted controller and return the status it reports
	function automatic status_t step_controller(input op_t op, input logic [KEY_W-1:0] key,
			input logic [DATA_W-1:0] data);
		status_t st;
		st = '0;
		case (op)
			OP_PRESS: begin
				keys_down[key] = 1'b1;
			end
			OP_RELEASE: begin
				keys_down[key] = 1'b0;
			end
			OP_WRITE: begin
				if (write_ready) begin
					last_byte = data;
					if (data[BIT_START] && scan_pos >= NUM_KEYS) begin
						scan_pos = '0;
						walk_key_map();
					end
					st.bell = data[BIT_BELL];
					write_ready = 1'b0;
					ready_tick_due = 1'b1;
				end
			end
			OP_READ: begin
				irq_level = 1'b0;
				st.read_data = code_latch;
			end
			OP_SCAN_TICK: begin
				if (scan_tick_due) begin
					scan_tick_due = 1'b0;
					walk_key_map();
				end
			end
			OP_READY_TICK: begin
				if (ready_tick_due) begin
					ready_tick_due = 1'b0;
					write_ready = 1'b1;
				end
			end
			default: ;
		endcase
		st.interrupt = irq_level;
		st.ready_res = write_ready;
		st.led_bits = last_byte[LED_W-1:0];
		st.scanning_active = (scan_pos < NUM_KEYS);
		return st;
	endfunction

	// Offer one item, wait for its accept, then queue what it should report
	task automatic send_item(input op_t op, input logic [KEY_W-1:0] key,
			input logic [DATA_W-1:0] data, input logic typed, input status_t want);
		status_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.key_code <= key;
		cmd_ch.write_data <= data;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = step_controller(op, key, data);
		status_due.push_back(typed ? want : predicted);
	endtask

	// Lower valid and hold until every queued status has come back
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (status_due.size() != 0);
	endtask

	// Draw one random item, with releases outweighing presses to keep the map sparse
	task automatic send_random_item();
		int unsigned pick;
		op_t op;
		pick = $urandom_range(99);
		if (pick < 12)
			op = OP_PRESS;
		else if (pick < 30)
			op = OP_RELEASE;
		else if (pick < 46)
			op = OP_WRITE;
		else if (pick < 64)
			op = OP_READ;
		else if (pick < 84)
			op = OP_SCAN_TICK;
		else
			op = OP_READY_TICK;
		send_item(op, KEY_W'($urandom_range(NUM_KEYS - 1)), DATA_W'($urandom_range(255)),
			1'b0, NOT_TYPED);
	endtask

	// Result receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin : result_sink
		int unsigned hold_left;
		int unsigned hold_seen;
		if (!arst_n) begin
			hold_left = 0;
			hold_seen = hold_asked;
			res_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = LONG_HOLD - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Check each accepted status against the oldest one queued; watch for a stuck run
	always @(posedge clk) begin : result_check
		status_t got;
		status_t want;
		if (!arst_n) begin
			stuck_cycles = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.read_data, res_ch.interrupt, res_ch.ready_res, res_ch.bell,
					res_ch.led_bits, res_ch.scanning_active};
				if (status_due.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("unexpected status item: %p", got);
				end else begin
					want = status_due.pop_front();
					if (got.read_data !== want.read_data || got.interrupt !== want.interrupt ||
							got.ready_res !== want.ready_res || got.bell !== want.bell ||
							got.led_bits !== want.led_bits ||
							got.scanning_active !== want.scanning_active) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS)
							$display("status mismatch: expected %p, actual %p", want, got);
					end
				end
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no item accepted for %0d cycles", stuck_cycles);
					$display("keyboard_matrix_scanner test failed");
					$finish;
				end
			end
		end
	end

	// Stimulus: reset, directed table, three random phases, then drain and report
	initial begin : stimulus
		int unsigned per_phase;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = '0;
		cmd_ch.key_code = '0;
		cmd_ch.write_data = '0;
		src_idle_pct = 38;
		snk_idle_pct = 46;
		hold_asked = 0;
		fault_count = 0;
		keys_down = '0;
		keys_down[NUM_KEYS-1] = 1'b1;
		scan_pos = 9'(NUM_KEYS);
		code_latch = '0;
		last_byte = '0;
		write_ready = 1'b1;
		irq_level = 1'b0;
		scan_tick_due = 1'b0;
		ready_tick_due = 1'b0;
		per_phase = RANDOM_ITEMS / 3;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].data,
				directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		// Receiver-heavy idling, then sender-heavy with a long hold-off, then none
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 38;
					snk_idle_pct = 46;
				end
				1: begin
					src_idle_pct = 46;
					snk_idle_pct = 38;
					hold_asked++;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			repeat (per_phase) send_random_item();
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0 && status_due.size() == 0)
			$display("keyboard_matrix_scanner test passed");
		else
			$display("keyboard_matrix_scanner test failed");
		$finish;
	end

endmodule

`default_nettype wire
